FILE: rtl/qwaa_pkg.sv
// shared types and constants of the quantized weighted-average accumulator
// used by qwaa_mac, qwaa_div_step and the top level; no dependencies
`default_nettype none

package qwaa_pkg;

   localparam int IDX_W  = 7;
   localparam int ACC_W  = 64;
   localparam int TOT_W  = 32;
   localparam int DEN_W  = 31;

   // one stage of the restoring divider
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
      logic             neg;     // numerator was negative
      logic             zero;    // weight sum not positive
      logic [DEN_W-1:0] den;
      logic [DEN_W-1:0] rem;
      logic [ACC_W-1:0] work;    // dividend bits shift out, quotient bits shift in
   } div_type;

endpackage

`default_nettype wire

FILE: rtl/qwaa_mac.sv
// multiply, accumulator memory read-modify-write and divider set-up stages
// depends on qwaa_pkg
`default_nettype none

module qwaa_mac #(
   parameter int ENTRY_COUNT = 128
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire logic                       in_valid,
   input  wire logic signed [15:0]         weight,
   input  wire logic signed [15:0]         v_quant,
   input  wire logic signed [31:0]         v_scale,
   input  wire logic [qwaa_pkg::IDX_W-1:0] elem_index,
   input  wire logic                       first_row,
   input  wire logic                       last_row,
   input  wire logic signed [31:0]         weight_total,
   output qwaa_pkg::div_type               div_out
);

   localparam int DEPTH = (ENTRY_COUNT < 128) ? ENTRY_COUNT : 128;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // stage 1: captured beat
   logic                       s1_valid_ff;
   logic signed [15:0]         s1_w_ff, s1_v_ff;
   logic signed [31:0]         s1_scale_ff, s1_tot_ff;
   logic [qwaa_pkg::IDX_W-1:0] s1_idx_ff;
   logic                       s1_first_ff, s1_last_ff;
   // stage 2: weight times value
   logic                       s2_valid_ff;
   logic signed [31:0]         s2_wv_ff, s2_scale_ff, s2_tot_ff;
   logic [qwaa_pkg::IDX_W-1:0] s2_idx_ff;
   logic                       s2_first_ff, s2_last_ff;
   // stage 3: full product, memory read data
   logic                       s3_valid_ff;
   logic signed [63:0]         s3_prod_ff;
   logic signed [31:0]         s3_tot_ff;
   logic [qwaa_pkg::IDX_W-1:0] s3_idx_ff;
   logic                       s3_first_ff, s3_last_ff;
   logic signed [63:0]         rd_q_ff;
   // stage 4: updated entry
   logic                       s4_valid_ff;
   logic signed [63:0]         s4_acc_ff;
   logic signed [31:0]         s4_tot_ff;
   logic [qwaa_pkg::IDX_W-1:0] s4_idx_ff;
   logic                       s4_last_ff;
   // stage 5: divider set-up
   qwaa_pkg::div_type          s5_ff, s5_in;

   logic signed [63:0] acc_mem [DEPTH];

   logic               in_range;
   logic signed [63:0] old_acc, sum, acc_in;
   logic               ovf;
   logic [63:0]        mag;

   assign in_range = (int'(elem_index) < ENTRY_COUNT);

   // the entry written in the cycle of our read is not in the read data yet
   assign old_acc = (s4_valid_ff && s4_idx_ff == s3_idx_ff) ? s4_acc_ff : rd_q_ff;
   assign sum     = old_acc + s3_prod_ff;
   assign ovf     = (old_acc[63] == s3_prod_ff[63]) && (sum[63] != old_acc[63]);

   always_comb begin
      if (s3_first_ff) begin
         acc_in = s3_prod_ff;
      end else if (ovf) begin
         acc_in = old_acc[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         acc_in = sum;
      end
   end

   assign mag = s4_acc_ff[63] ? (64'd0 - 64'(s4_acc_ff)) : 64'(s4_acc_ff);

   always_comb begin
      s5_in.valid = s4_valid_ff && s4_last_ff;
      s5_in.idx   = s4_idx_ff;
      s5_in.neg   = s4_acc_ff[63];
      s5_in.zero  = (s4_tot_ff <= 0);
      s5_in.den   = s4_tot_ff[qwaa_pkg::DEN_W-1:0];
      s5_in.rem   = '0;
      s5_in.work  = mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid && in_range;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_w_ff     <= weight;
         s1_v_ff     <= v_quant;
         s1_scale_ff <= v_scale;
         s1_tot_ff   <= weight_total;
         s1_idx_ff   <= elem_index;
         s1_first_ff <= first_row;
         s1_last_ff  <= last_row;

         s2_wv_ff    <= s1_w_ff * s1_v_ff;
         s2_scale_ff <= s1_scale_ff;
         s2_tot_ff   <= s1_tot_ff;
         s2_idx_ff   <= s1_idx_ff;
         s2_first_ff <= s1_first_ff;
         s2_last_ff  <= s1_last_ff;

         s3_prod_ff  <= 64'(s2_wv_ff) * 64'(s2_scale_ff);
         s3_tot_ff   <= s2_tot_ff;
         s3_idx_ff   <= s2_idx_ff;
         s3_first_ff <= s2_first_ff;
         s3_last_ff  <= s2_last_ff;
         rd_q_ff     <= acc_mem[s2_idx_ff[AW-1:0]];

         s4_acc_ff   <= acc_in;
         s4_tot_ff   <= s3_tot_ff;
         s4_idx_ff   <= s3_idx_ff;
         s4_last_ff  <= s3_last_ff;
      end
   end

   // divider set-up register, only its valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s5_ff.valid <= 1'b0;
      end else if (advance) begin
         s5_ff.valid <= s5_in.valid;
      end
      if (advance) begin
         s5_ff.idx   <= s5_in.idx;
         s5_ff.neg   <= s5_in.neg;
         s5_ff.zero  <= s5_in.zero;
         s5_ff.den   <= s5_in.den;
         s5_ff.rem   <= s5_in.rem;
         s5_ff.work  <= s5_in.work;
      end
   end

   // accumulator memory, written as the entry leaves stage 3
   always_ff @(posedge clock) begin
      if (advance && s3_valid_ff) begin
         acc_mem[s3_idx_ff[AW-1:0]] <= acc_in;
      end
   end

   assign div_out = s5_ff;

endmodule

`default_nettype wire

FILE: rtl/qwaa_div_step.sv
// one registered bit step of the restoring divider
// depends on qwaa_pkg
`default_nettype none

module qwaa_div_step (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  wire qwaa_pkg::div_type d_in,
   output qwaa_pkg::div_type d_out
);

   qwaa_pkg::div_type step_ff, step_in;
   logic [qwaa_pkg::DEN_W:0] trial, diff;
   logic                     take;

   assign trial = {d_in.rem, d_in.work[qwaa_pkg::ACC_W-1]};
   assign diff  = trial - {1'b0, d_in.den};
   assign take  = (trial >= {1'b0, d_in.den});

   always_comb begin
      step_in      = d_in;
      step_in.rem  = take ? diff[qwaa_pkg::DEN_W-1:0] : trial[qwaa_pkg::DEN_W-1:0];
      step_in.work = {d_in.work[qwaa_pkg::ACC_W-2:0], take};
   end

   // only the valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff.valid <= 1'b0;
      end else if (advance) begin
         step_ff.valid <= step_in.valid;
      end
      if (advance) begin
         step_ff.idx  <= step_in.idx;
         step_ff.neg  <= step_in.neg;
         step_ff.zero <= step_in.zero;
         step_ff.den  <= step_in.den;
         step_ff.rem  <= step_in.rem;
         step_ff.work <= step_in.work;
      end
   end

   assign d_out = step_ff;

endmodule

`default_nettype wire

FILE: rtl/quantized_weighted_average_accumulate.sv
// top level: weighted accumulate per head-dimension entry and normalising divide
// depends on qwaa_pkg, qwaa_mac and qwaa_div_step
`default_nettype none

// channel   direction  carries
// req_      in         weight, value element, scale, index, weight sum; tuser first, tlast last
// rsp_      out        index and normalised value, one beat per in-range last-row beat
//
// one beat accepted every cycle unless rsp_ stalls; a req beat reaches rsp_ through
// 4 stages of multiply and accumulator update, 1 set-up, 64 divider bit stages and 1 output
// the divider is fully pipelined, one quotient bit per stage
// reset clears only the valid bits; accumulator entries are undefined until a first-row beat
// a stall on rsp_ freezes the whole pipeline; req_tready follows it in the same cycle

module quantized_weighted_average_accumulate #(
   parameter int ENTRY_COUNT = 128
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // weight[15:0], v_quant[31:16], v_scale[63:32], elem_index[70:64],
   // weight_total[102:71], zero pad[103]
   input  wire logic [103:0] req_tdata,
   input  wire logic         req_tuser,   // first_row
   input  wire logic         req_tlast,   // last_row
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // out_index[6:0], out_value[70:7], zero pad[71]
   output logic [71:0]       rsp_tdata
);

   localparam int STEPS = qwaa_pkg::ACC_W;

   logic              advance;
   qwaa_pkg::div_type chain [STEPS+1];

   logic                       out_valid_ff;
   logic [qwaa_pkg::IDX_W-1:0] out_idx_ff;
   logic [63:0]                out_val_ff, out_val_in;
   qwaa_pkg::div_type          fin;

   // whole pipeline moves unless a finished beat is held up
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   qwaa_mac #(
      .ENTRY_COUNT (ENTRY_COUNT)
   ) u_mac (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (req_tvalid),
      .weight       (req_tdata[15:0]),
      .v_quant      (req_tdata[31:16]),
      .v_scale      (req_tdata[63:32]),
      .elem_index   (req_tdata[70:64]),
      .first_row    (req_tuser),
      .last_row     (req_tlast),
      .weight_total (req_tdata[102:71]),
      .div_out      (chain[0])
   );

   // one quotient bit per stage, most significant first
   for (genvar g = 0; g < STEPS; g++) begin : g_div
      qwaa_div_step u_step (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .d_in    (chain[g]),
         .d_out   (chain[g+1])
      );
   end

   assign fin = chain[STEPS];

   // sign restore, positive overflow clamp and non-positive weight sum
   always_comb begin
      if (fin.zero) begin
         out_val_in = '0;
      end else if (fin.neg) begin
         out_val_in = 64'd0 - fin.work;
      end else if (fin.work[63]) begin
         out_val_in = {1'b0, {63{1'b1}}};
      end else begin
         out_val_in = fin.work;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= fin.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_idx_ff <= fin.idx;
         out_val_ff <= out_val_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_val_ff, out_idx_ff};

endmodule

`default_nettype wire
